>>> design/prt_pkg.sv
package prt_pkg;

  localparam int unsigned TimeW = 48;
  localparam int unsigned InstW = 5;
  localparam logic [15:0] DefaultTimeoutReset = 16'd5000;

  typedef enum logic [1:0] {
    KIND_SEND  = 2'd0,
    KIND_RESP  = 2'd1,
    KIND_CHECK = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_RECORDED    = 3'd0,
    ST_FULL        = 3'd1,
    ST_UNTRACKED   = 3'd2,
    ST_MATCHED     = 3'd3,
    ST_UNMATCHED   = 3'd4,
    ST_EXPIRED     = 3'd5,
    ST_NONE_EXPIRED = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_CHECK
  } fsm_e;

  typedef struct packed {
    logic [1:0]       channel;
    logic [5:0]       mtype;
    logic [7:0]       cmd;
    logic [InstW-1:0] inst;
    logic [7:0]       token;
    logic [TimeW-1:0] expiry;
  } entry_t;

  typedef struct packed {
    logic             append;
    logic             search;
    logic             remove;
    logic             by_expiry;
    logic [1:0]       key_channel;
    logic [5:0]       key_type;
    logic [7:0]       key_cmd;
    logic [InstW-1:0] key_inst;
    logic [TimeW-1:0] now;
    entry_t           new_entry;
  } cell_ctrl_t;

endpackage

>>> design/prt_in_if.sv
interface prt_in_if
  import prt_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic [1:0]       channel;
  logic             is_request;
  logic [5:0]       msg_type_code;
  logic [7:0]       command;
  logic [InstW-1:0] instance_req;
  logic [15:0]      req_timeout;
  logic [7:0]       token;
  logic [TimeW-1:0] now_ms;

  modport source (
    output valid, kind, channel, is_request, msg_type_code, command, instance_req,
    output req_timeout, token, now_ms,
    input  ready
  );
  modport sink (
    input  valid, kind, channel, is_request, msg_type_code, command, instance_req,
    input  req_timeout, token, now_ms,
    output ready
  );
endinterface

>>> design/prt_out_if.sv
interface prt_out_if
  import prt_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [2:0]       status;
  logic [InstW-1:0] assigned_inst;
  logic [1:0]       out_channel;
  logic [5:0]       out_type;
  logic [7:0]       out_cmd;
  logic [7:0]       out_token;
  logic             last;

  modport source (
    output valid, status, assigned_inst, out_channel, out_type, out_cmd, out_token, last,
    input  ready
  );
  modport sink (
    input  valid, status, assigned_inst, out_channel, out_type, out_cmd, out_token, last,
    output ready
  );
endinterface

>>> design/prt_cfg_if.sv
interface prt_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (
    output valid, data,
    input  ready
  );
  modport sink (
    input  valid, data,
    output ready
  );
endinterface

>>> design/prt_cell.sv
module prt_cell
  import prt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       prev_valid_i,
  input  logic       next_valid_i,
  input  entry_t     next_entry_i,
  input  logic       hit_i,
  input  logic       more_i,
  input  entry_t     found_i,
  output logic       valid_o,
  output entry_t     entry_o,
  output logic       hit_o,
  output logic       more_o,
  output entry_t     found_o
);

  logic   valid_q, valid_d;
  entry_t entry_q, entry_d;
  logic   key_match;
  logic   expired;
  logic   sel;
  logic   kill;

  assign key_match = (entry_q.channel == ctrl_i.key_channel) &&
                     (entry_q.inst == ctrl_i.key_inst) &&
                     (entry_q.mtype == ctrl_i.key_type) &&
                     (entry_q.cmd == ctrl_i.key_cmd);
  assign expired   = (entry_q.expiry <= ctrl_i.now);
  assign sel       = ctrl_i.search & valid_q & (ctrl_i.by_expiry ? expired : key_match);
  assign kill      = ctrl_i.remove & (hit_i | sel);

  assign hit_o   = hit_i | sel;
  assign more_o  = more_i | (hit_i & sel);
  assign found_o = (hit_i || !sel) ? found_i : entry_q;
  assign valid_o = valid_q;
  assign entry_o = entry_q;

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (kill) begin
      valid_d = next_valid_i;
      entry_d = next_entry_i;
    end else if (ctrl_i.append && !valid_q && prev_valid_i) begin
      valid_d = 1'b1;
      entry_d = ctrl_i.new_entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

>>> design/pending_request_tracker_top.sv
// Channel  Direction  Transfer carries
// in_i     sink       one send, response or timeout-check item
// out_o    source     one result: status, instance, entry fields, last
// cfg_i    sink       default timeout in ms, 16 bits
//
// An input transfer is taken only while the table is idle; a send or response item is
// executed in the EXEC state, which registers its result on the output.
// A timeout check removes one expired entry per cycle from the row of cells while the
// result output is not stalled, and returns to idle after the last expired entry.
// Reset empties the table, clears the instance counters and sets the default to 5000.
// A stalled result holds the table: no entry moves until the result is taken.
module pending_request_tracker_top
  import prt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH  = 16,
  parameter int unsigned NUM_CHANNELS = 4
) (
  input logic    clk_i,
  input logic    rst_ni,
  prt_in_if.sink   in_i,
  prt_out_if.source out_o,
  prt_cfg_if.sink  cfg_i
);

  localparam int unsigned CiW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  function automatic logic [CiW-1:0] ch_idx(input logic [1:0] ch);
    logic [4:0] v;
    v = {3'b000, ch};
    for (int k = 0; k < 3; k++) begin
      if (v >= 5'(NUM_CHANNELS)) begin
        v = v - 5'(NUM_CHANNELS);
      end
    end
    return CiW'(v);
  endfunction

  fsm_e state_q, state_d;

  logic [15:0]      dflt_q;
  logic [InstW-1:0] inst_cnt_q [NUM_CHANNELS];
  logic             cnt_inc;

  logic [1:0]       op_kind_q;
  logic [1:0]       op_ch_q;
  logic             op_isreq_q;
  logic [5:0]       op_type_q;
  logic [7:0]       op_cmd_q;
  logic [InstW-1:0] op_iq_q;
  logic [7:0]       op_tok_q;
  logic [TimeW-1:0] op_exp_q;
  logic [TimeW-1:0] op_now_q;
  logic [15:0]      tmo_eff;
  logic             in_fire;

  logic             out_valid_q, out_valid_d;
  logic             out_load;
  logic             out_free;
  logic [2:0]       st_q, st_d;
  logic [InstW-1:0] oinst_q, oinst_d;
  logic [1:0]       och_q, och_d;
  logic [5:0]       otype_q, otype_d;
  logic [7:0]       ocmd_q, ocmd_d;
  logic [7:0]       otok_q, otok_d;
  logic             olast_q, olast_d;

  cell_ctrl_t       ctrl;
  logic [CiW-1:0]   ci;
  logic             full;
  logic             is_send_req;

  logic [TABLE_DEPTH-1:0] vmask;
  entry_t                 ent [TABLE_DEPTH];
  logic                   hit [TABLE_DEPTH+1];
  logic                   more [TABLE_DEPTH+1];
  entry_t                 found [TABLE_DEPTH+1];

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == FSM_IDLE);
  assign in_fire     = in_i.valid & in_i.ready;
  assign tmo_eff     = (in_i.req_timeout == 16'd0) ? dflt_q : in_i.req_timeout;
  assign out_free    = !out_valid_q || out_o.ready;
  assign ci          = ch_idx(op_ch_q);
  assign full        = vmask[TABLE_DEPTH-1];
  assign is_send_req = (state_q == FSM_EXEC) && (op_kind_q == KIND_SEND) && op_isreq_q;

  assign ctrl.append      = is_send_req && !full && out_free;
  assign ctrl.search      = ((state_q == FSM_EXEC) && (op_kind_q == KIND_RESP)) ||
                            (state_q == FSM_CHECK);
  assign ctrl.remove      = ctrl.search && out_free;
  assign ctrl.by_expiry   = (state_q == FSM_CHECK);
  assign ctrl.key_channel = op_ch_q;
  assign ctrl.key_type    = op_type_q;
  assign ctrl.key_cmd     = op_cmd_q;
  assign ctrl.key_inst    = op_iq_q;
  assign ctrl.now         = op_now_q;
  assign ctrl.new_entry   = '{channel: op_ch_q, mtype: op_type_q, cmd: op_cmd_q,
                              inst: inst_cnt_q[ci], token: op_tok_q, expiry: op_exp_q};

  assign hit[0]   = 1'b0;
  assign more[0]  = 1'b0;
  assign found[0] = '0;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic   prev_v;
    logic   next_v;
    entry_t next_e;
    if (g == 0) begin : g_head
      assign prev_v = 1'b1;
    end else begin : g_body
      assign prev_v = vmask[g-1];
    end
    if (g == TABLE_DEPTH - 1) begin : g_tail
      assign next_v = 1'b0;
      assign next_e = '0;
    end else begin : g_link
      assign next_v = vmask[g+1];
      assign next_e = ent[g+1];
    end
    prt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .prev_valid_i(prev_v),
      .next_valid_i(next_v),
      .next_entry_i(next_e),
      .hit_i       (hit[g]),
      .more_i      (more[g]),
      .found_i     (found[g]),
      .valid_o     (vmask[g]),
      .entry_o     (ent[g]),
      .hit_o       (hit[g+1]),
      .more_o      (more[g+1]),
      .found_o     (found[g+1])
    );
  end

  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    cnt_inc  = 1'b0;
    st_d     = ST_NONE_EXPIRED;
    oinst_d  = '0;
    och_d    = op_ch_q;
    otype_d  = op_type_q;
    ocmd_d   = op_cmd_q;
    otok_d   = op_tok_q;
    olast_d  = 1'b1;
    case (state_q)
      FSM_IDLE: begin
        if (in_fire) begin
          state_d = (in_i.kind == KIND_CHECK) ? FSM_CHECK : FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        if (out_free) begin
          state_d = FSM_IDLE;
          case (op_kind_q)
            KIND_SEND: begin
              out_load = 1'b1;
              if (!op_isreq_q) begin
                st_d = ST_UNTRACKED;
              end else if (full) begin
                st_d = ST_FULL;
              end else begin
                st_d    = ST_RECORDED;
                oinst_d = inst_cnt_q[ci];
                cnt_inc = 1'b1;
              end
            end
            KIND_RESP: begin
              out_load = 1'b1;
              if (hit[TABLE_DEPTH]) begin
                st_d    = ST_MATCHED;
                oinst_d = found[TABLE_DEPTH].inst;
                och_d   = found[TABLE_DEPTH].channel;
                otype_d = found[TABLE_DEPTH].mtype;
                ocmd_d  = found[TABLE_DEPTH].cmd;
                otok_d  = found[TABLE_DEPTH].token;
              end else begin
                st_d    = ST_UNMATCHED;
                oinst_d = op_iq_q;
              end
            end
            default: begin
              out_load = 1'b0;
            end
          endcase
        end
      end
      FSM_CHECK: begin
        if (out_free) begin
          out_load = 1'b1;
          if (hit[TABLE_DEPTH]) begin
            st_d    = ST_EXPIRED;
            oinst_d = found[TABLE_DEPTH].inst;
            och_d   = found[TABLE_DEPTH].channel;
            otype_d = found[TABLE_DEPTH].mtype;
            ocmd_d  = found[TABLE_DEPTH].cmd;
            otok_d  = found[TABLE_DEPTH].token;
            olast_d = !more[TABLE_DEPTH];
            if (!more[TABLE_DEPTH]) begin
              state_d = FSM_IDLE;
            end
          end else begin
            st_d    = ST_NONE_EXPIRED;
            och_d   = '0;
            otype_d = '0;
            ocmd_d  = '0;
            otok_d  = '0;
            state_d = FSM_IDLE;
          end
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      out_valid_q <= 1'b0;
      dflt_q      <= DefaultTimeoutReset;
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        inst_cnt_q[k] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        dflt_q <= cfg_i.data;
      end
      if (cnt_inc) begin
        inst_cnt_q[ci] <= inst_cnt_q[ci] + InstW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_kind_q  <= in_i.kind;
      op_ch_q    <= in_i.channel;
      op_isreq_q <= in_i.is_request;
      op_type_q  <= in_i.msg_type_code;
      op_cmd_q   <= in_i.command;
      op_iq_q    <= in_i.instance_req;
      op_tok_q   <= in_i.token;
      op_exp_q   <= in_i.now_ms + TimeW'(tmo_eff);
      op_now_q   <= in_i.now_ms;
    end
    if (out_load) begin
      st_q    <= st_d;
      oinst_q <= oinst_d;
      och_q   <= och_d;
      otype_q <= otype_d;
      ocmd_q  <= ocmd_d;
      otok_q  <= otok_d;
      olast_q <= olast_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = st_q;
  assign out_o.assigned_inst = oinst_q;
  assign out_o.out_channel   = och_q;
  assign out_o.out_type      = otype_q;
  assign out_o.out_cmd       = ocmd_q;
  assign out_o.out_token     = otok_q;
  assign out_o.last          = olast_q;

  a_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vmask & (vmask + TABLE_DEPTH'(1))) == '0)
    else $error("Table entries are not packed toward the head.");

  a_no_append_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.append |-> !full)
    else $error("Append attempted into a full table.");

  a_one_removal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 ($countones(vmask) + 1 >= $countones($past(vmask))))
    else $error("More than one entry left the table in one cycle.");

  a_expired_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_CHECK && hit[TABLE_DEPTH]) |-> (found[TABLE_DEPTH].expiry <= op_now_q))
    else $error("Reported entry has not expired.");

endmodule

>>> test/prt_result_checker.sv
module prt_result_checker
  import prt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH  = 16,
  parameter int unsigned NUM_CHANNELS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  prt_in_if           req_i,
  prt_out_if          res_i,
  prt_cfg_if          cfg_i,
  output int unsigned mismatch_count_o,
  output int unsigned backlog_o
);

  typedef struct packed {
    status_e          status;
    logic [InstW-1:0] inst;
    logic [1:0]       channel;
    logic [5:0]       mtype;
    logic [7:0]       cmd;
    logic [7:0]       token;
    logic             last;
  } outcome_t;

  entry_t           tracked_entries[$];
  outcome_t         pending_outcomes[$];
  logic [InstW-1:0] inst_count[NUM_CHANNELS];
  logic [15:0]      default_timeout;

  task automatic push_outcome(status_e st, logic [InstW-1:0] inst, logic [1:0] ch,
                              logic [5:0] ty, logic [7:0] cmd, logic [7:0] tok,
                              logic last);
    outcome_t o;
    o.status  = st;
    o.inst    = inst;
    o.channel = ch;
    o.mtype   = ty;
    o.cmd     = cmd;
    o.token   = tok;
    o.last    = last;
    pending_outcomes.push_back(o);
  endtask

  task automatic apply_tracker_item();
    entry_t      e;
    logic [15:0] span;
    int unsigned idx;
    int unsigned removed;
    bit          hit;
    case (req_i.kind)
      KIND_SEND: begin
        if (!req_i.is_request) begin
          push_outcome(ST_UNTRACKED, '0, req_i.channel, req_i.msg_type_code, req_i.command,
                       req_i.token, 1'b1);
        end else if (tracked_entries.size() >= TABLE_DEPTH) begin
          push_outcome(ST_FULL, '0, req_i.channel, req_i.msg_type_code, req_i.command,
                       req_i.token, 1'b1);
        end else begin
          span = (req_i.req_timeout == 16'd0) ? default_timeout : req_i.req_timeout;
          e.channel = req_i.channel;
          e.mtype   = req_i.msg_type_code;
          e.cmd     = req_i.command;
          e.inst    = inst_count[req_i.channel % NUM_CHANNELS];
          e.token   = req_i.token;
          e.expiry  = req_i.now_ms + TimeW'(span);
          inst_count[req_i.channel % NUM_CHANNELS] = e.inst + 1'b1;
          tracked_entries.push_back(e);
          push_outcome(ST_RECORDED, e.inst, e.channel, e.mtype, e.cmd, e.token, 1'b1);
        end
      end
      KIND_RESP: begin
        hit = 1'b0;
        for (idx = 0; idx < tracked_entries.size(); idx++) begin
          e = tracked_entries[idx];
          if (e.channel == req_i.channel && e.inst == req_i.instance_req &&
              e.mtype == req_i.msg_type_code && e.cmd == req_i.command) begin
            push_outcome(ST_MATCHED, e.inst, e.channel, e.mtype, e.cmd, e.token, 1'b1);
            tracked_entries.delete(idx);
            hit = 1'b1;
            break;
          end
        end
        if (!hit) begin
          push_outcome(ST_UNMATCHED, req_i.instance_req, req_i.channel, req_i.msg_type_code,
                       req_i.command, req_i.token, 1'b1);
        end
      end
      KIND_CHECK: begin
        idx = 0;
        removed = 0;
        while (idx < tracked_entries.size()) begin
          e = tracked_entries[idx];
          if (e.expiry <= req_i.now_ms) begin
            push_outcome(ST_EXPIRED, e.inst, e.channel, e.mtype, e.cmd, e.token, 1'b0);
            tracked_entries.delete(idx);
            removed++;
          end else begin
            idx++;
          end
        end
        if (removed == 0) begin
          push_outcome(ST_NONE_EXPIRED, '0, '0, '0, '0, '0, 1'b1);
        end else begin
          pending_outcomes[pending_outcomes.size() - 1].last = 1'b1;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatch_count_o++;
    end
  endtask

  task automatic check_result();
    outcome_t want;
    if (pending_outcomes.size() == 0) begin
      $display("%0t: result with no outstanding item: expected none, got status %0d inst %0d",
               $time, res_i.status, res_i.assigned_inst);
      mismatch_count_o++;
    end else begin
      want = pending_outcomes.pop_front();
      compare_field("status", 8'(want.status), 8'(res_i.status));
      compare_field("assigned_inst", 8'(want.inst), 8'(res_i.assigned_inst));
      compare_field("out_channel", 8'(want.channel), 8'(res_i.out_channel));
      compare_field("out_type", 8'(want.mtype), 8'(res_i.out_type));
      compare_field("out_cmd", want.cmd, res_i.out_cmd);
      compare_field("out_token", want.token, res_i.out_token);
      compare_field("last", 8'(want.last), 8'(res_i.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tracked_entries.delete();
      pending_outcomes.delete();
      foreach (inst_count[c]) inst_count[c] = '0;
      default_timeout = DefaultTimeoutReset;
      mismatch_count_o = 0;
      backlog_o <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) default_timeout = cfg_i.data;
      if (res_i.valid && res_i.ready) check_result();
      if (req_i.valid && req_i.ready) apply_tracker_item();
      backlog_o <= pending_outcomes.size();
    end
  end

endmodule

>>> test/tb_pending_request_tracker_top.sv
module tb_pending_request_tracker_top;
  import prt_pkg::*;

  localparam int unsigned Depth = 16;
  localparam int unsigned Channels = 4;
  localparam logic [1:0] KindUnused = 2'd3;
  localparam logic [TimeW-1:0] TimeMax = '1;
  localparam int unsigned ItemsPerPhase = 76;

  typedef struct {
    logic [1:0]       ch;
    logic [5:0]       ty;
    logic [7:0]       cmd;
    logic [InstW-1:0] inst;
  } open_req_t;

  logic             clk;
  logic             rst_n;
  int unsigned      mismatch_count;
  int unsigned      backlog;
  bit               eager;
  logic [TimeW-1:0] uptime_ms;
  open_req_t        open_reqs[$];

  prt_in_if  item_if();
  prt_out_if result_if();
  prt_cfg_if cfg_if();

  pending_request_tracker_top #(
    .TABLE_DEPTH (Depth),
    .NUM_CHANNELS(Channels)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (item_if),
    .out_o (result_if),
    .cfg_i (cfg_if)
  );

  prt_result_checker #(
    .TABLE_DEPTH (Depth),
    .NUM_CHANNELS(Channels)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .req_i           (item_if),
    .res_i           (result_if),
    .cfg_i           (cfg_if),
    .mismatch_count_o(mismatch_count),
    .backlog_o       (backlog)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("pending_request_tracker_top: mismatch");
    $finish;
  end

  function automatic int unsigned draw_gap();
    return eager ? 0 : $urandom_range(0, 19);
  endfunction

  // Requests the block has recorded, so that responses can be aimed at live entries.
  always @(posedge clk) begin
    if (rst_n && result_if.valid && result_if.ready) begin
      if (result_if.status == ST_RECORDED) begin
        open_reqs.push_back('{result_if.out_channel, result_if.out_type, result_if.out_cmd,
                              result_if.assigned_inst});
        if (open_reqs.size() > 40) void'(open_reqs.pop_front());
      end else if (result_if.status == ST_EXPIRED || result_if.status == ST_MATCHED) begin
        for (int k = 0; k < open_reqs.size(); k++) begin
          if (open_reqs[k].ch == result_if.out_channel && open_reqs[k].ty == result_if.out_type &&
              open_reqs[k].cmd == result_if.out_cmd &&
              open_reqs[k].inst == result_if.assigned_inst) begin
            open_reqs.delete(k);
            break;
          end
        end
      end
    end
  end

  initial begin
    int unsigned gap;
    result_if.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      gap = draw_gap();
      if (gap != 0) begin
        result_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk); while (!(result_if.valid && result_if.ready));
    end
  end

  task automatic send_item(logic [1:0] kind, logic [1:0] ch, logic isreq, logic [5:0] ty,
                           logic [7:0] cmd, logic [InstW-1:0] inst, logic [15:0] tmo,
                           logic [7:0] tok, logic [TimeW-1:0] now);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_if.kind          <= kind;
    item_if.channel       <= ch;
    item_if.is_request    <= isreq;
    item_if.msg_type_code <= ty;
    item_if.command       <= cmd;
    item_if.instance_req  <= inst;
    item_if.req_timeout   <= tmo;
    item_if.token         <= tok;
    item_if.now_ms        <= now;
    item_if.valid         <= 1'b1;
    do @(posedge clk); while (!(item_if.valid && item_if.ready));
  endtask

  task automatic settle();
    item_if.valid <= 1'b0;
    @(posedge clk);
    wait (backlog == 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_default(logic [15:0] value);
    settle();
    cfg_if.data  <= value;
    cfg_if.valid <= 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic random_item(output bit counted);
    int unsigned pick;
    int unsigned at;
    logic [15:0] tmo;
    open_req_t   r;
    counted = 1'b1;
    pick = $urandom_range(0, 99);
    uptime_ms = uptime_ms + TimeW'($urandom_range(0, 1500));
    if (pick < 45) begin
      case ($urandom_range(0, 4))
        0: tmo = '0;
        1: tmo = 16'($urandom);
        default: tmo = 16'($urandom_range(1, 6000));
      endcase
      send_item(KIND_SEND, 2'($urandom), 1'b1, 6'($urandom), 8'($urandom), 5'($urandom), tmo,
                8'($urandom), uptime_ms);
    end else if (pick < 50) begin
      send_item(KIND_SEND, 2'($urandom), 1'b0, 6'($urandom), 8'($urandom), 5'($urandom),
                16'($urandom), 8'($urandom), uptime_ms);
    end else if (pick < 75) begin
      if (open_reqs.size() != 0 && $urandom_range(0, 9) < 8) begin
        at = $urandom_range(0, open_reqs.size() - 1);
        r = open_reqs[at];
        open_reqs.delete(at);
        if ($urandom_range(0, 9) == 0) r.cmd = r.cmd ^ 8'(1 << $urandom_range(0, 7));
      end else begin
        r.ch   = 2'($urandom);
        r.ty   = 6'($urandom);
        r.cmd  = 8'($urandom);
        r.inst = 5'($urandom);
      end
      send_item(KIND_RESP, r.ch, 1'($urandom), r.ty, r.cmd, r.inst, 16'($urandom),
                8'($urandom), uptime_ms);
    end else if (pick < 97) begin
      if ($urandom_range(0, 3) == 0) uptime_ms = uptime_ms + TimeW'($urandom_range(0, 60000));
      send_item(KIND_CHECK, 2'($urandom), 1'($urandom), 6'($urandom), 8'($urandom),
                5'($urandom), 16'($urandom), 8'($urandom), uptime_ms);
    end else begin
      counted = 1'b0;
      send_item(KindUnused, 2'($urandom), 1'($urandom), 6'($urandom), 8'($urandom),
                5'($urandom), 16'($urandom), 8'($urandom), TimeW'({$urandom, $urandom}));
    end
  endtask

  initial begin
    logic [TimeW-1:0] fill_ms;
    logic [15:0]      phase_default[5];
    int unsigned      done;
    bit               counted;
    rst_n                 <= 1'b0;
    item_if.valid         <= 1'b0;
    item_if.kind          <= KIND_SEND;
    item_if.channel       <= '0;
    item_if.is_request    <= 1'b0;
    item_if.msg_type_code <= '0;
    item_if.command       <= '0;
    item_if.instance_req  <= '0;
    item_if.req_timeout   <= '0;
    item_if.token         <= '0;
    item_if.now_ms        <= '0;
    cfg_if.valid          <= 1'b0;
    cfg_if.data           <= '0;
    eager = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(KIND_SEND, 2'd3, 1'b0, 6'h3F, 8'hFF, 5'h1F, 16'hFFFF, 8'hFF, TimeMax);
    send_item(KIND_CHECK, '0, 1'b0, '0, '0, '0, '0, '0, '0);
    send_item(KIND_RESP, 2'd3, 1'b1, 6'h3F, 8'hFF, 5'h1F, 16'hFFFF, 8'hFF, TimeMax);
    send_item(KindUnused, 2'd3, 1'b1, 6'h3F, 8'hFF, 5'h1F, 16'hFFFF, 8'hFF, TimeMax);
    // Fill the table near the top of the time range; zero timeouts use the
    // reset default and wrap past zero.
    fill_ms = TimeMax - TimeW'(4095);
    for (int i = 0; i < Depth; i++) begin
      send_item(KIND_SEND, 2'(i % Channels), 1'b1, 6'(i), 8'(255 - i), '0,
                (i % 2 == 1) ? 16'(i) : 16'd0, 8'(i), fill_ms);
    end
    send_item(KIND_SEND, '0, 1'b1, '0, '0, '0, '0, '0, '0);
    send_item(KIND_RESP, 2'd1, 1'b0, 6'd1, 8'd254, 5'd0, '0, '0, fill_ms);
    send_item(KIND_CHECK, '0, 1'b0, '0, '0, '0, '0, '0, fill_ms + TimeW'(100));
    send_item(KIND_CHECK, '0, 1'b0, '0, '0, '0, '0, '0, TimeW'(2000));
    send_item(KIND_CHECK, '0, 1'b0, '0, '0, '0, '0, '0, TimeW'(2000));
    uptime_ms = TimeW'(2000);

    phase_default[0] = 16'd1;
    phase_default[1] = 16'd0;
    phase_default[2] = 16'hFFFF;
    phase_default[3] = 16'($urandom_range(2, 65534));
    phase_default[4] = 16'($urandom_range(2, 65534));
    for (int p = 0; p < 5; p++) begin
      write_default(phase_default[p]);
      if (p == 4) uptime_ms = TimeMax - TimeW'(100000);
      done = 0;
      while (done < ItemsPerPhase) begin
        if (done % 25 == 0) eager = ($urandom_range(0, 2) == 0);
        random_item(counted);
        if (counted) done++;
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("pending_request_tracker_top: match");
    end else begin
      $display("pending_request_tracker_top: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
design/prt_pkg.sv
design/prt_in_if.sv
design/prt_out_if.sv
design/prt_cfg_if.sv
design/prt_cell.sv
design/pending_request_tracker_top.sv
test/prt_result_checker.sv
test/tb_pending_request_tracker_top.sv
